/* hw/rtl/dapc_pkg.sv */
// Shared types, constants and lookup tables for the drive-and-aim PWM controller.
`default_nettype none
package dapc_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int THRESH_W        = 10;
    localparam int CFG_IDX_W       = 2;
    localparam int CODE_W          = 8;
    localparam int PHASE_W         = 5;
    localparam int MODE_W          = 3;
    localparam int OUT_W           = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_ABOVE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKWARD_BELOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RIGHT_BELOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LEFT_ABOVE  = 2'd3;

    // threshold reset values: 0.2 V, 0.1 V, 0.64 V, 0.76 V at 3.325 V / 1023 counts
    localparam logic [THRESH_W-1:0] RST_FORWARD_ABOVE    = 10'd61;
    localparam logic [THRESH_W-1:0] RST_BACKWARD_BELOW   = 10'd31;
    localparam logic [THRESH_W-1:0] RST_TURN_RIGHT_BELOW = 10'd197;
    localparam logic [THRESH_W-1:0] RST_TURN_LEFT_ABOVE  = 10'd233;

    // command bytes
    localparam logic [CODE_W-1:0] CMD_AUTO       = 8'hAA;
    localparam logic [CODE_W-1:0] CMD_AIM_TRIG_LO = 8'h40;
    localparam logic [CODE_W-1:0] CMD_AIM_TILT_HI = 8'h48;
    localparam logic [CODE_W-1:0] CMD_AIM_TILT_LO = 8'h44;
    localparam logic [CODE_W-1:0] CMD_AIM_PAN_LO  = 8'h42;
    localparam logic [CODE_W-1:0] CMD_AIM_PAN_HI  = 8'h41;
    localparam logic [CODE_W-1:0] CMD_AIM_TRIG_HI = 8'h50;
    localparam logic [CODE_W-1:0] CMD_MOVE_86    = 8'h86;
    localparam logic [CODE_W-1:0] CMD_MOVE_81    = 8'h81;
    localparam logic [CODE_W-1:0] CMD_MOVE_82    = 8'h82;
    localparam logic [CODE_W-1:0] CMD_MOVE_88    = 8'h88;
    localparam logic [CODE_W-1:0] CMD_MOVE_84    = 8'h84;
    localparam logic [CODE_W-1:0] CMD_MOVE_89    = 8'h89;
    localparam logic [CODE_W-1:0] CMD_MOVE_8A    = 8'h8A;
    localparam logic [CODE_W-1:0] CMD_MOVE_85    = 8'h85;

    // aim modes
    localparam logic [MODE_W-1:0] MODE_TRIG_LO = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRIG_HI = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TILT_LO = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PAN_HI  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PAN_LO  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TILT_HI = 3'd5;
    localparam logic [MODE_W-1:0] MODE_COUNT   = 3'd6;

    // servo pin select: bit2 trigger, bit1 tilt, bit0 pan
    localparam logic [2:0] PIN_TRIGGER = 3'b100;
    localparam logic [2:0] PIN_TILT    = 3'b010;
    localparam logic [2:0] PIN_PAN     = 3'b001;
    localparam logic [2:0] PIN_NONE    = 3'b000;

    localparam logic [PHASE_W-1:0] LIMIT_LONG  = 5'd19;
    localparam logic [PHASE_W-1:0] LIMIT_SHORT = 5'd9;

    // wheel pins: bit3 right0, bit2 right1, bit1 left0, bit0 left1
    localparam logic [3:0] WHEELS_STOP  = 4'h0;
    localparam logic [3:0] WHEELS_FWD   = 4'hA;
    localparam logic [3:0] WHEELS_REV   = 4'h5;
    localparam logic [3:0] WHEELS_RIGHT = 4'h8;
    localparam logic [3:0] WHEELS_LEFT  = 4'h4;

    typedef struct packed {
        logic [THRESH_W-1:0] forward_above;
        logic [THRESH_W-1:0] backward_below;
        logic [THRESH_W-1:0] turn_right_below;
        logic [THRESH_W-1:0] turn_left_above;
    } t_thresh;

    typedef struct packed {
        logic       pwm_active;
        logic [2:0] servo;   // trigger, tilt, pan
        logic       laser;
        logic [3:0] wheels;  // right0, right1, left0, left1
    } t_pins;

    function automatic logic [PHASE_W-1:0] mode_limit(input logic [MODE_W-1:0] mode);
        logic [PHASE_W-1:0] lim;
        unique case (mode)
            MODE_TILT_LO, MODE_TILT_HI: lim = LIMIT_SHORT;
            default:                    lim = LIMIT_LONG;
        endcase
        return lim;
    endfunction

    function automatic logic [PHASE_W-1:0] mode_duty(input logic [MODE_W-1:0] mode);
        logic [PHASE_W-1:0] duty;
        unique case (mode)
            MODE_TRIG_LO: duty = 5'd1;
            MODE_TRIG_HI: duty = 5'd15;
            MODE_TILT_LO: duty = 5'd2;
            MODE_PAN_HI:  duty = 5'd17;
            MODE_PAN_LO:  duty = 5'd6;
            MODE_TILT_HI: duty = 5'd8;
            default:      duty = 5'd0;
        endcase
        return duty;
    endfunction

    function automatic logic [2:0] mode_pin(input logic [MODE_W-1:0] mode);
        logic [2:0] pin;
        unique case (mode)
            MODE_TRIG_LO, MODE_TRIG_HI: pin = PIN_TRIGGER;
            MODE_TILT_LO, MODE_TILT_HI: pin = PIN_TILT;
            MODE_PAN_HI, MODE_PAN_LO:   pin = PIN_PAN;
            default:                    pin = PIN_NONE;
        endcase
        return pin;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/dapc_cfg.sv */
// Threshold register file written through the configuration channel.
`default_nettype none
module dapc_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [dapc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dapc_pkg::THRESH_W-1:0]  i_cfg_data,
    output dapc_pkg::t_thresh                   o_thresh
);
    import dapc_pkg::*;

    t_thresh r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.forward_above    <= RST_FORWARD_ABOVE;
            r_thresh.backward_below   <= RST_BACKWARD_BELOW;
            r_thresh.turn_right_below <= RST_TURN_RIGHT_BELOW;
            r_thresh.turn_left_above  <= RST_TURN_LEFT_ABOVE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FORWARD_ABOVE:    r_thresh.forward_above    <= i_cfg_data;
                REG_BACKWARD_BELOW:   r_thresh.backward_below   <= i_cfg_data;
                REG_TURN_RIGHT_BELOW: r_thresh.turn_right_below <= i_cfg_data;
                REG_TURN_LEFT_ABOVE:  r_thresh.turn_left_above  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_thresh = r_thresh;

endmodule
`default_nettype wire

/* hw/rtl/dapc_core.sv */
// Controller state: PWM phase generator, command decode and auto steering.
`default_nettype none
module dapc_core #(
    parameter int SAMPLE_BITS = dapc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic                          i_cmd,
    input  wire logic [dapc_pkg::CODE_W-1:0]   i_code,
    input  wire logic [SAMPLE_BITS-1:0]        i_range,
    input  wire logic [SAMPLE_BITS-1:0]        i_bearing,
    input  wire dapc_pkg::t_thresh             i_thresh,
    output dapc_pkg::t_pins                    o_pins
);
    import dapc_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PHASE_W-1:0] r_limit, n_limit;
    logic [MODE_W-1:0]  r_mode, n_mode;
    logic               r_enable, n_enable;
    logic [3:0]         r_wheels, n_wheels;
    logic               r_laser, n_laser;
    logic [2:0]         r_servo, n_servo;

    logic [PHASE_W-1:0] phase_inc;
    logic [PHASE_W-1:0] phase_step;
    logic [CMP_W-1:0]   range_x, bearing_x;
    logic [CMP_W-1:0]   fwd_x, back_x, right_x, left_x;
    logic [3:0]         auto_wheels;

    assign phase_inc  = r_phase + PHASE_W'(1);
    assign phase_step = (phase_inc > r_limit) ? '0 : phase_inc;

    assign range_x   = CMP_W'(i_range);
    assign bearing_x = CMP_W'(i_bearing);
    assign fwd_x     = CMP_W'(i_thresh.forward_above);
    assign back_x    = CMP_W'(i_thresh.backward_below);
    assign right_x   = CMP_W'(i_thresh.turn_right_below);
    assign left_x    = CMP_W'(i_thresh.turn_left_above);

    always_comb begin
        priority if (range_x > fwd_x)       auto_wheels = WHEELS_FWD;
        else if (range_x < back_x)          auto_wheels = WHEELS_REV;
        else if (bearing_x < right_x)       auto_wheels = WHEELS_RIGHT;
        else if (bearing_x > left_x)        auto_wheels = WHEELS_LEFT;
        else                                auto_wheels = WHEELS_STOP;
    end

    always_comb begin
        n_phase  = r_phase;
        n_limit  = r_limit;
        n_mode   = r_mode;
        n_enable = r_enable;
        n_wheels = r_wheels;
        n_laser  = r_laser;
        n_servo  = r_servo;
        if (i_accept) begin
            if (!i_cmd) begin
                if (r_enable) begin
                    n_phase = phase_step;
                    // limit reload lags the wrap check by one tick
                    if (r_mode < MODE_COUNT) begin
                        n_limit = mode_limit(r_mode);
                        n_servo = (phase_step <= mode_duty(r_mode)) ? mode_pin(r_mode)
                                                                    : PIN_NONE;
                    end
                end
            end else begin
                n_mode   = MODE_TRIG_LO;
                n_enable = 1'b0;
                unique case (i_code)
                    CMD_AUTO:        n_wheels = auto_wheels;
                    CMD_AIM_TRIG_LO: begin n_mode = MODE_TRIG_LO; n_enable = 1'b1; end
                    CMD_AIM_TILT_HI: begin n_mode = MODE_TILT_HI; n_enable = 1'b1; end
                    CMD_AIM_TILT_LO: begin n_mode = MODE_TILT_LO; n_enable = 1'b1; end
                    CMD_AIM_PAN_LO:  begin n_mode = MODE_PAN_LO;  n_enable = 1'b1; end
                    CMD_AIM_PAN_HI:  begin n_mode = MODE_PAN_HI;  n_enable = 1'b1; end
                    CMD_AIM_TRIG_HI: begin n_mode = MODE_TRIG_HI; n_enable = 1'b1; end
                    CMD_MOVE_86: begin n_wheels = 4'h4; n_laser = 1'b1; end
                    CMD_MOVE_81: begin n_wheels = 4'h6; n_laser = 1'b1; end
                    CMD_MOVE_82: begin n_wheels = 4'h9; n_laser = 1'b1; end
                    CMD_MOVE_88: begin n_wheels = 4'hA; n_laser = 1'b1; end
                    CMD_MOVE_84: begin n_wheels = 4'h5; n_laser = 1'b1; end
                    CMD_MOVE_89: begin n_wheels = 4'h2; n_laser = 1'b1; end
                    CMD_MOVE_8A: begin n_wheels = 4'h8; n_laser = 1'b1; end
                    CMD_MOVE_85: begin n_wheels = 4'h1; n_laser = 1'b1; end
                    default:     begin n_wheels = WHEELS_STOP; n_laser = 1'b1; end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_limit  <= LIMIT_LONG;
            r_mode   <= MODE_TRIG_LO;
            r_enable <= 1'b1;
            r_wheels <= WHEELS_STOP;
            r_laser  <= 1'b0;
            r_servo  <= PIN_NONE;
        end else begin
            r_phase  <= n_phase;
            r_limit  <= n_limit;
            r_mode   <= n_mode;
            r_enable <= n_enable;
            r_wheels <= n_wheels;
            r_laser  <= n_laser;
            r_servo  <= n_servo;
        end
    end

    assign o_pins.pwm_active = r_enable;
    assign o_pins.servo      = r_servo;
    assign o_pins.laser      = r_laser;
    assign o_pins.wheels     = r_wheels;

endmodule
`default_nettype wire

/* hw/rtl/drive_and_aim_pwm_controller.sv */
// Top level of the drive-and-aim PWM controller: stream handshake and result item.
//
// Each input item is either a PWM tick (tuser low) or a command byte with two
// sensor samples (tuser high); each produces exactly one result item with the
// levels of all nine pins. The state registers are updated at the accepting
// edge and double as the result register, which the next item may replace in
// the same cycle the current result is taken, so one item per clock is
// sustained when the output side keeps tready high.
// Threshold registers are written through the cfg channel, which is always ready.
`default_nettype none
module drive_and_aim_pwm_controller #(
    parameter int SAMPLE_BITS = dapc_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W = ((dapc_pkg::CODE_W + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    // command_code, range_sample, bearing_sample (from bit 0 up), zero fill
    input  wire logic [IN_W-1:0]                s_axis_tdata,
    // cmd
    input  wire logic                           s_axis_tuser,
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // right_pin0, right_pin1, left_pin0, left_pin1, laser_on, trigger_pwm,
    // tilt_pwm, pan_pwm, pwm_active (from bit 0 up), zero fill
    output      logic [dapc_pkg::OUT_W-1:0]     m_axis_tdata,
    input  wire logic                           i_cfg_valid,
    output      logic                           o_cfg_ready,
    input  wire logic [dapc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dapc_pkg::THRESH_W-1:0]  i_cfg_data
);
    import dapc_pkg::*;

    localparam int RANGE_LO   = CODE_W;
    localparam int BEARING_LO = CODE_W + SAMPLE_BITS;

    logic    r_out_valid;
    logic    accept;
    t_thresh thresh;
    t_pins   pins;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    dapc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_thresh    (thresh)
    );

    dapc_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_cmd     (s_axis_tuser),
        .i_code    (s_axis_tdata[CODE_W-1:0]),
        .i_range   (s_axis_tdata[RANGE_LO +: SAMPLE_BITS]),
        .i_bearing (s_axis_tdata[BEARING_LO +: SAMPLE_BITS]),
        .i_thresh  (thresh),
        .o_pins    (pins)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0,
                            pins.pwm_active,
                            pins.servo[0],
                            pins.servo[1],
                            pins.servo[2],
                            pins.laser,
                            pins.wheels[0],
                            pins.wheels[1],
                            pins.wheels[2],
                            pins.wheels[3]};

endmodule
`default_nettype wire
